>>> src/stepper_position_controller_defines.svh
// Assertion macros for the stepper position controller
`ifndef STEPPER_POSITION_CONTROLLER_DEFINES_SVH
`define STEPPER_POSITION_CONTROLLER_DEFINES_SVH
`ifndef ASSERT_OFF
`define SPC_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define SPC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define SPC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SPC_ASSERT(label, cond, msg)
`define SPC_ASSERT_IMP(label, ante, cons, msg)
`define SPC_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

>>> src/spc_pkg.sv
// Shared types and constants of the stepper position controller
package spc_pkg;

  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_ADC  = 2'd1;
  localparam logic [1:0] KIND_STEP = 2'd2;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_POT  = 2'd1;
  localparam logic [1:0] MODE_TERM = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_P_LO  = 8'h70;
  localparam logic [7:0] CH_P_UP  = 8'h50;
  localparam logic [7:0] CH_T_LO  = 8'h74;
  localparam logic [7:0] CH_T_UP  = 8'h54;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  localparam int          CMD_LEN     = 4;
  localparam logic [2:0]  CMD_LEN_C   = 3'(CMD_LEN);
  localparam int          DEG_W       = 16;
  localparam int          DEG_PER_REV = 360;
  localparam logic signed [DEG_W-1:0] DIGIT_BASE = 16'sd48;
  localparam logic signed [DEG_W-1:0] DEC_HUND   = 16'sd100;
  localparam logic signed [DEG_W-1:0] DEC_TEN    = 16'sd10;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [3:0] FULL_SEQ [4] = '{4'h3, 4'h6, 4'hC, 4'h9};
  localparam logic [3:0] HALF_SEQ [8] = '{4'h1, 4'h3, 4'h2, 4'h6,
                                          4'h4, 4'hC, 4'h8, 4'h9};

  typedef enum logic [2:0] {
    OP_NOP,
    OP_NULL,
    OP_PICK_POT,
    OP_PICK_TERM,
    OP_EOL,
    OP_CHAR,
    OP_ADC,
    OP_STEP
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  ch;
    logic [11:0] adc;
  } cmd_t;

  typedef struct packed {
    logic [3:0]         coil_pattern;
    logic signed [31:0] position;
    logic signed [31:0] target;
    logic [1:0]         mode;
    logic               stepped;
    logic               arrived;
    logic               echo_valid;
    logic [7:0]         echo_char;
  } result_t;

endpackage

>>> src/stepper_position_controller.sv
// Top level of the stepper position controller
//
//   channel  handshake              payload
//   in_      in_valid / in_stall    in_kind, in_char_code, in_adc_value
//   out_     out_valid / out_stall  out_coil_pattern .. out_echo_char
//
// One word per cycle in and out unless stalled; every input word gives exactly
// one result word. A complete signed command ended by CR or LF holds the back
// end in S_DIV and S_APPLY: degrees times steps per turn, reciprocal multiply by
// 1/360, add to position. Reset is synchronous, active low; no clearing pass.
// A two-word queue parts front and back; in_stall rises only when it is full.
`include "stepper_position_controller_defines.svh"
module stepper_position_controller #(
  parameter int unsigned STEPS_PER_REV = 2048
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_kind,
  input  logic [7:0]         in_char_code,
  input  logic [11:0]        in_adc_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         out_coil_pattern,
  output logic signed [31:0] out_position,
  output logic signed [31:0] out_target,
  output logic [1:0]         out_mode,
  output logic               out_stepped,
  output logic               out_arrived,
  output logic               out_echo_valid,
  output logic [7:0]         out_echo_char
);
  import spc_pkg::*;

  logic    q_push, q_full, q_pop, q_head_valid;
  cmd_t    q_in_cmd, q_head_cmd;
  result_t res;

  spc_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_char_code (in_char_code),
    .in_adc_value (in_adc_value),
    .q_full       (q_full),
    .push         (q_push),
    .cmd          (q_in_cmd)
  );

  spc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_in_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_cmd   (q_head_cmd)
  );

  spc_back #(
    .STEPS_PER_REV (STEPS_PER_REV)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_cmd   (q_head_cmd),
    .pop        (q_pop),
    .res_valid  (out_valid),
    .res_stall  (out_stall),
    .res        (res)
  );

  assign out_coil_pattern = res.coil_pattern;
  assign out_position     = res.position;
  assign out_target       = res.target;
  assign out_mode         = res.mode;
  assign out_stepped      = res.stepped;
  assign out_arrived      = res.arrived;
  assign out_echo_valid   = res.echo_valid;
  assign out_echo_char    = res.echo_char;

  `SPC_ASSERT_NXT(a_push_fills, in_valid && !in_stall, q_head_valid, "accepted word not queued")
  `SPC_ASSERT_IMP(a_pop_head, q_pop, q_head_valid, "pop from empty queue")
  `SPC_ASSERT_IMP(a_arrive_step, out_valid && out_arrived, out_stepped, "arrival without step")
  `SPC_ASSERT_IMP(a_echo_term, out_valid && out_echo_valid, out_mode == MODE_TERM, "echo outside terminal mode")

endmodule

>>> src/spc_front.sv
// Front end: accept input words and classify them into queue commands
module spc_front (
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [1:0]    in_kind,
  input  logic [7:0]    in_char_code,
  input  logic [11:0]   in_adc_value,
  input  logic          q_full,
  output logic          push,
  output spc_pkg::cmd_t cmd
);
  import spc_pkg::*;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    cmd.ch  = in_char_code;
    cmd.adc = in_adc_value;
    unique case (in_kind)
      KIND_CHAR: begin
        unique case (in_char_code) inside
          CH_NUL:           cmd.op = OP_NULL;
          CH_P_LO, CH_P_UP: cmd.op = OP_PICK_POT;
          CH_T_LO, CH_T_UP: cmd.op = OP_PICK_TERM;
          CH_CR, CH_LF:     cmd.op = OP_EOL;
          default:          cmd.op = OP_CHAR;
        endcase
      end
      KIND_ADC:  cmd.op = OP_ADC;
      KIND_STEP: cmd.op = OP_STEP;
      default:   cmd.op = OP_NOP;
    endcase
  end

endmodule

>>> src/spc_queue.sv
// Short command queue between front end and back end
module spc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  spc_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output spc_pkg::cmd_t head_cmd
);
  import spc_pkg::*;

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> src/spc_back.sv
// Back end: motor state, command execution and result register
module spc_back #(
  parameter int unsigned STEPS_PER_REV = 2048
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  spc_pkg::cmd_t    head_cmd,
  output logic             pop,
  output logic             res_valid,
  input  logic             res_stall,
  output spc_pkg::result_t res
);
  import spc_pkg::*;

  localparam int SPR_W     = $clog2(STEPS_PER_REV + 1);
  localparam int PROD_W    = DEG_W + SPR_W + 1;
  localparam int MAG_W     = PROD_W - 1;
  localparam int GUARD_W   = $clog2(DEG_PER_REV);
  localparam int SHIFT     = MAG_W + GUARD_W;
  localparam int RECIP_W   = MAG_W + 1;
  localparam int QPROD_W   = MAG_W + RECIP_W;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(DEG_PER_REV) - 64'd1) / 64'(DEG_PER_REV);
  localparam logic [RECIP_W-1:0]    RECIP = RECIP_W'(RECIP_FULL);
  localparam logic signed [SPR_W:0] SPR_S = (SPR_W + 1)'(STEPS_PER_REV);

  typedef enum logic [1:0] {S_RUN, S_DIV, S_APPLY} state_t;

  state_t             state_r, state_nxt;
  logic [1:0]         mode_r, mode_nxt;
  logic [31:0]        pos_r, pos_nxt;
  logic [31:0]        tgt_r, tgt_nxt;
  logic [2:0]         phase_r, phase_nxt;
  logic [3:0]         coil_r, coil_nxt;
  logic [7:0]         chars_r [CMD_LEN];
  logic [7:0]         chars_nxt [CMD_LEN];
  logic [2:0]         count_r, count_nxt;
  logic               res_valid_r, res_valid_nxt;
  result_t            res_r, res_nxt;

  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic                     minus_r, minus_nxt;
  logic [31:0]              quot_r, quot_nxt;
  logic                     neg_r, neg_nxt;
  logic [7:0]               echo_r, echo_nxt;

  logic signed [DEG_W-1:0] dig1, dig2, dig3, deg;
  logic [MAG_W-1:0]        mag;
  logic [QPROD_W-1:0]      qprod;
  logic                    slot_free, emit, stepped, arrived, echo_v, up;
  logic [7:0]              echo_c;
  logic [1:0]              ph_full;
  logic [2:0]              ph_half;
  logic [31:0]             steps;

  assign res_valid = res_valid_r;
  assign res       = res_r;
  assign slot_free = !res_valid_r || !res_stall;

  always_comb begin
    dig1 = $signed({{(DEG_W-8){1'b0}}, chars_r[1]}) - DIGIT_BASE;
    dig2 = $signed({{(DEG_W-8){1'b0}}, chars_r[2]}) - DIGIT_BASE;
    dig3 = $signed({{(DEG_W-8){1'b0}}, chars_r[3]}) - DIGIT_BASE;
    deg  = dig1 * DEC_HUND + dig2 * DEC_TEN + dig3;
    mag  = prod_r[PROD_W-1] ? MAG_W'(-prod_r) : MAG_W'(prod_r);
    qprod = QPROD_W'(mag) * QPROD_W'(RECIP);
    steps = neg_r ? -quot_r : quot_r;
    up    = $signed(tgt_r) > $signed(pos_r);
    ph_half = up ? phase_r + 3'd1 : phase_r - 3'd1;
    ph_full = up ? phase_r[1:0] + 2'd1 : phase_r[1:0] + 2'd3;
  end

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    pos_nxt   = pos_r;
    tgt_nxt   = tgt_r;
    phase_nxt = phase_r;
    coil_nxt  = coil_r;
    chars_nxt = chars_r;
    count_nxt = count_r;
    prod_nxt  = prod_r;
    minus_nxt = minus_r;
    quot_nxt  = quot_r;
    neg_nxt   = neg_r;
    echo_nxt  = echo_r;
    pop       = 1'b0;
    emit      = 1'b0;
    stepped   = 1'b0;
    arrived   = 1'b0;
    echo_v    = 1'b0;
    echo_c    = '0;
    unique case (state_r)
      S_RUN: begin
        if (head_valid && slot_free) begin
          pop  = 1'b1;
          emit = 1'b1;
          unique case (head_cmd.op) inside
            OP_PICK_POT: mode_nxt = MODE_POT;
            OP_PICK_TERM, OP_CHAR: begin
              if (head_cmd.op == OP_PICK_TERM || mode_r == MODE_TERM) begin
                mode_nxt = MODE_TERM;
                echo_v   = 1'b1;
                echo_c   = head_cmd.ch;
                if (count_r < CMD_LEN_C) begin
                  chars_nxt[count_r[1:0]] = head_cmd.ch;
                  count_nxt = count_r + 3'd1;
                end
              end
            end
            OP_EOL: begin
              if (mode_r == MODE_TERM) begin
                echo_v    = 1'b1;
                echo_c    = head_cmd.ch;
                count_nxt = '0;
                if (count_r == CMD_LEN_C &&
                    (chars_r[0] == CH_PLUS || chars_r[0] == CH_MINUS)) begin
                  emit      = 1'b0;
                  prod_nxt  = PROD_W'(deg) * PROD_W'(SPR_S);
                  minus_nxt = (chars_r[0] == CH_MINUS);
                  echo_nxt  = head_cmd.ch;
                  state_nxt = S_DIV;
                end
              end
            end
            OP_ADC: begin
              if (mode_r == MODE_POT) begin
                tgt_nxt = 32'(head_cmd.adc);
              end
            end
            OP_STEP: begin
              if ((mode_r == MODE_POT || mode_r == MODE_TERM) && pos_r != tgt_r) begin
                if (mode_r == MODE_POT) begin
                  phase_nxt = ph_half;
                  coil_nxt  = HALF_SEQ[ph_half];
                end else begin
                  phase_nxt = {1'b0, ph_full};
                  coil_nxt  = FULL_SEQ[ph_full];
                end
                pos_nxt = up ? pos_r + 32'd1 : pos_r - 32'd1;
                stepped = 1'b1;
                arrived = (mode_r == MODE_TERM) && (pos_nxt == tgt_r);
              end
            end
            default: ;
          endcase
        end
      end
      S_DIV: begin
        quot_nxt  = 32'(qprod >> SHIFT);
        neg_nxt   = prod_r[PROD_W-1] ^ minus_r;
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        if (slot_free) begin
          tgt_nxt   = pos_r + steps;
          emit      = 1'b1;
          echo_v    = 1'b1;
          echo_c    = echo_r;
          state_nxt = S_RUN;
        end
      end
      default: state_nxt = S_RUN;
    endcase

    res_valid_nxt = emit || (res_valid_r && res_stall);
    res_nxt       = res_r;
    if (emit) begin
      res_nxt.coil_pattern = coil_nxt;
      res_nxt.position     = $signed(pos_nxt);
      res_nxt.target       = $signed(tgt_nxt);
      res_nxt.mode         = mode_nxt;
      res_nxt.stepped      = stepped;
      res_nxt.arrived      = arrived;
      res_nxt.echo_valid   = echo_v;
      res_nxt.echo_char    = echo_c;
    end
  end

  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    minus_r <= minus_nxt;
    quot_r  <= quot_nxt;
    neg_r   <= neg_nxt;
    echo_r  <= echo_nxt;
    res_r   <= res_nxt;
    if (!rst_n) begin
      state_r     <= S_RUN;
      mode_r      <= MODE_IDLE;
      pos_r       <= '0;
      tgt_r       <= '0;
      phase_r     <= '0;
      coil_r      <= '0;
      chars_r     <= '{default: '0};
      count_r     <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      pos_r       <= pos_nxt;
      tgt_r       <= tgt_nxt;
      phase_r     <= phase_nxt;
      coil_r      <= coil_nxt;
      chars_r     <= chars_nxt;
      count_r     <= count_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the stepper position controller, with scripted and random words
module testbench;
  import spc_pkg::*;

  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_X_LO = 8'h78;
  localparam int unsigned STEPS_PER_TURN = 2048;
  localparam int PHASE_WORDS = 510;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_REPORTS = 100;
  localparam logic [3:0] FULL_COILS [4] = '{4'h3, 4'h6, 4'hC, 4'h9};
  localparam logic [3:0] HALF_COILS [8] = '{4'h1, 4'h3, 4'h2, 4'h6,
                                            4'h4, 4'hC, 4'h8, 4'h9};

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  ch;
    logic [11:0] adc;
  } word_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_kind = KIND_NONE;
  logic [7:0]         in_char_code = CH_NUL;
  logic [11:0]        in_adc_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [3:0]         out_coil_pattern;
  logic signed [31:0] out_position;
  logic signed [31:0] out_target;
  logic [1:0]         out_mode;
  logic               out_stepped;
  logic               out_arrived;
  logic               out_echo_valid;
  logic [7:0]         out_echo_char;

  stepper_position_controller #(
    .STEPS_PER_REV(STEPS_PER_TURN)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_kind(in_kind),
    .in_char_code(in_char_code),
    .in_adc_value(in_adc_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_coil_pattern(out_coil_pattern),
    .out_position(out_position),
    .out_target(out_target),
    .out_mode(out_mode),
    .out_stepped(out_stepped),
    .out_arrived(out_arrived),
    .out_echo_valid(out_echo_valid),
    .out_echo_char(out_echo_char)
  );

  always #5 clk = ~clk;

  word_t   pending_words[$];
  result_t expected_status[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int error_count = 0;
  int checked_words = 0;
  int queued_words = 0;

  logic [1:0]  motor_mode = MODE_IDLE;
  logic [31:0] motor_pos = '0;
  logic [31:0] motor_tgt = '0;
  logic [2:0]  motor_phase = '0;
  logic [3:0]  motor_coils = '0;
  logic [7:0]  cmd_buf [4] = '{default: 8'h00};
  int          cmd_len = 0;

  function automatic result_t predict_motor(word_t w);
    result_t r;
    int deg;
    int steps;
    logic up;
    r = '0;
    case (w.kind)
      KIND_CHAR: begin
        if (w.ch == CH_P_LO || w.ch == CH_P_UP) motor_mode = MODE_POT;
        else if (w.ch == CH_T_LO || w.ch == CH_T_UP) motor_mode = MODE_TERM;
        if (motor_mode == MODE_TERM && w.ch != CH_NUL) begin
          r.echo_valid = 1'b1;
          r.echo_char = w.ch;
          if (w.ch == CH_CR || w.ch == CH_LF) begin
            if (cmd_len == 4 && (cmd_buf[0] == CH_PLUS || cmd_buf[0] == CH_MINUS)) begin
              deg = (int'(cmd_buf[1]) - 48) * 100 + (int'(cmd_buf[2]) - 48) * 10
                  + (int'(cmd_buf[3]) - 48);
              steps = deg * int'(STEPS_PER_TURN) / 360;
              if (cmd_buf[0] == CH_MINUS) steps = -steps;
              motor_tgt = motor_pos + 32'(steps);
            end
            cmd_len = 0;
          end else if (cmd_len < 4) begin
            cmd_buf[cmd_len] = w.ch;
            cmd_len++;
          end
        end
      end
      KIND_ADC: begin
        if (motor_mode == MODE_POT) motor_tgt = {20'h0, w.adc};
      end
      KIND_STEP: begin
        if ((motor_mode == MODE_POT || motor_mode == MODE_TERM) && motor_pos != motor_tgt) begin
          up = $signed(motor_tgt) > $signed(motor_pos);
          if (motor_mode == MODE_POT) begin
            motor_phase = up ? motor_phase + 3'd1 : motor_phase - 3'd1;
            motor_coils = HALF_COILS[motor_phase];
          end else begin
            motor_phase = {1'b0, (up ? motor_phase[1:0] + 2'd1 : motor_phase[1:0] + 2'd3)};
            motor_coils = FULL_COILS[motor_phase[1:0]];
          end
          motor_pos = up ? motor_pos + 32'd1 : motor_pos - 32'd1;
          r.stepped = 1'b1;
          r.arrived = (motor_mode == MODE_TERM) && (motor_pos == motor_tgt);
        end
      end
      default: ;
    endcase
    r.coil_pattern = motor_coils;
    r.position = motor_pos;
    r.target = motor_tgt;
    r.mode = motor_mode;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    if (error_count < MAX_REPORTS)
      $display("mismatch at word %0d, %s: got %0d, expected %0d",
               checked_words, what, got, want);
    error_count++;
  endtask

  task automatic queue_word(logic [1:0] kind, logic [7:0] ch, logic [11:0] adc);
    pending_words.push_back({kind, ch, adc});
    queued_words++;
  endtask

  task automatic queue_random(int count);
    int stop_at;
    int len;
    logic [7:0] c;
    stop_at = queued_words + count;
    while (queued_words < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          if ($urandom_range(0, 3) == 0)
            queue_word(KIND_CHAR, $urandom_range(0, 1) ? CH_T_LO : CH_T_UP,
                       12'($urandom_range(0, 4095)));
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 6) : 4;
          for (int i = 0; i < len; i++) begin
            if (i == 0 && $urandom_range(0, 9) != 0)
              c = $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
            else if (i == 0 || $urandom_range(0, 9) == 0)
              c = 8'($urandom_range(0, 255));
            else if (i == 1 && $urandom_range(0, 4) != 0)
              c = CH_ZERO;
            else
              c = CH_ZERO + 8'($urandom_range(0, 9));
            queue_word(KIND_CHAR, c, 12'($urandom_range(0, 4095)));
          end
          queue_word(KIND_CHAR, $urandom_range(0, 1) ? CH_CR : CH_LF,
                     12'($urandom_range(0, 4095)));
          repeat ($urandom_range(0, 40))
            queue_word(KIND_STEP, 8'($urandom_range(0, 255)), 12'($urandom_range(0, 4095)));
        end
        4, 5, 6: begin
          if ($urandom_range(0, 1) == 0)
            queue_word(KIND_CHAR, $urandom_range(0, 1) ? CH_P_LO : CH_P_UP,
                       12'($urandom_range(0, 4095)));
          queue_word(KIND_ADC, 8'($urandom_range(0, 255)),
                     ($urandom_range(0, 9) < 7) ? 12'($urandom_range(0, 40))
                                                : 12'($urandom_range(0, 4095)));
          repeat ($urandom_range(0, 40))
            queue_word(KIND_STEP, 8'($urandom_range(0, 255)), 12'($urandom_range(0, 4095)));
        end
        7, 8: begin
          repeat ($urandom_range(1, 30))
            queue_word(KIND_STEP, 8'($urandom_range(0, 255)), 12'($urandom_range(0, 4095)));
        end
        default: begin
          repeat ($urandom_range(1, 4))
            queue_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                       12'($urandom_range(0, 4095)));
        end
      endcase
    end
  endtask

  task automatic drain_all();
    while (pending_words.size() != 0 || expected_status.size() != 0 || in_valid)
      @(negedge clk);
  endtask

  always @(posedge clk) begin : drive_words
    word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        expected_status.push_back(predict_motor({in_kind, in_char_code, in_adc_value}));
      if (!in_valid || !in_stall) begin
        if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          w = pending_words.pop_front();
          in_valid <= 1'b1;
          in_kind <= w.kind;
          in_char_code <= w.ch;
          in_adc_value <= w.adc;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      holds_served <= hold_requests;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_status
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_status.size() == 0) begin
        report_mismatch("word with none expected", 1, 0);
      end else begin
        want = expected_status.pop_front();
        if (out_coil_pattern !== want.coil_pattern)
          report_mismatch("coil_pattern", out_coil_pattern, want.coil_pattern);
        if (out_position !== want.position)
          report_mismatch("position", out_position, want.position);
        if (out_target !== want.target)
          report_mismatch("target", out_target, want.target);
        if (out_mode !== want.mode)
          report_mismatch("mode", out_mode, want.mode);
        if (out_stepped !== want.stepped)
          report_mismatch("stepped", out_stepped, want.stepped);
        if (out_arrived !== want.arrived)
          report_mismatch("arrived", out_arrived, want.arrived);
        if (out_echo_valid !== want.echo_valid)
          report_mismatch("echo_valid", out_echo_valid, want.echo_valid);
        if (out_echo_char !== want.echo_char)
          report_mismatch("echo_char", out_echo_char, want.echo_char);
      end
      checked_words++;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_idle_pct = 34;
    recv_idle_pct = 61;

    queue_word(KIND_NONE, 8'hFF, 12'hFFF);
    queue_word(KIND_STEP, 8'hFF, 12'hFFF);
    queue_word(KIND_ADC, CH_NUL, 12'hFFF);
    queue_word(KIND_CHAR, CH_P_UP, 12'h000);
    queue_word(KIND_ADC, CH_NUL, 12'h003);
    repeat (4) queue_word(KIND_STEP, CH_NUL, 12'h000);
    queue_word(KIND_ADC, CH_NUL, 12'h000);
    queue_word(KIND_STEP, CH_NUL, 12'h000);
    queue_word(KIND_CHAR, CH_NUL, 12'h000);
    queue_word(KIND_CHAR, CH_T_LO, 12'h000);
    queue_word(KIND_CHAR, CH_CR, 12'h000);
    queue_word(KIND_CHAR, CH_PLUS, 12'h000);
    queue_word(KIND_CHAR, CH_ZERO, 12'h000);
    queue_word(KIND_CHAR, CH_ZERO, 12'h000);
    queue_word(KIND_CHAR, CH_ZERO + 8'd1, 12'h000);
    queue_word(KIND_CHAR, CH_CR, 12'h000);
    repeat (6) queue_word(KIND_STEP, CH_NUL, 12'h000);
    queue_word(KIND_CHAR, CH_MINUS, 12'h000);
    queue_word(KIND_CHAR, 8'hFF, 12'h000);
    queue_word(KIND_CHAR, CH_NUL, 12'h000);
    queue_word(KIND_CHAR, CH_ZERO + 8'd9, 12'h000);
    queue_word(KIND_CHAR, CH_X_LO, 12'h000);
    queue_word(KIND_CHAR, CH_LF, 12'h000);
    queue_word(KIND_STEP, CH_NUL, 12'h000);
    queue_word(KIND_CHAR, CH_MINUS, 12'h000);
    queue_word(KIND_CHAR, CH_ZERO + 8'd1, 12'h000);
    queue_word(KIND_CHAR, CH_CR, 12'h000);
    queue_word(KIND_CHAR, CH_P_LO, 12'h000);
    queue_random(PHASE_WORDS);
    drain_all();

    // hold the receiver off while words keep coming
    hold_requests++;
    queue_random(40);
    drain_all();

    send_idle_pct = 61;
    recv_idle_pct = 34;
    queue_random(PHASE_WORDS);
    drain_all();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(PHASE_WORDS);
    drain_all();

    repeat (20) @(negedge clk);
    if (error_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/spc_pkg.sv
src/spc_front.sv
src/spc_queue.sv
src/spc_back.sv
src/stepper_position_controller.sv
verif/testbench.sv
